@@ src/rgtp_pkg.sv @@
// Shared types, character codes and sizes for the geometry string parser.
`timescale 1ns / 1ps
`default_nettype none
package rgtp_pkg;

	localparam int unsigned FIELD_CHARS_DEF = 5;

	localparam int unsigned CHARS_W = 4;   // holds a character count of up to 15
	localparam int unsigned ACC_W   = 17;
	localparam int unsigned VAL_W   = ACC_W + 1;
	localparam int unsigned CNT_W   = 3;
	localparam int unsigned NUM_VALS = 4;
	localparam int unsigned RES_BITS = NUM_VALS * VAL_W + CNT_W;
	localparam int unsigned OUT_W    = ((RES_BITS + 7) / 8) * 8;

	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_X     = 8'h78;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;

	typedef enum logic [5:0] {
		ST_WIDTH  = 6'b000001,
		ST_SEP    = 6'b000010,
		ST_HEIGHT = 6'b000100,
		ST_XOFF   = 6'b001000,
		ST_YOFF   = 6'b010000,
		ST_DONE   = 6'b100000
	} stage_t;

	typedef struct packed {
		stage_t                         stage;
		logic                           phase;   // 0: sign or digit expected
		logic                           neg;
		logic [CHARS_W-1:0]             chars;
		logic [ACC_W-1:0]               acc;
		logic [NUM_VALS-1:0][VAL_W-1:0] vals;    // width, height, x, y
		logic [CNT_W-1:0]               count;
	} parse_state_t;

	localparam parse_state_t PARSE_RESET = '{
		stage: ST_WIDTH,
		phase: 1'b0,
		neg:   1'b0,
		chars: '0,
		acc:   '0,
		vals:  '0,
		count: '0
	};

endpackage
`default_nettype wire

@@ src/rect_geometry_text_parser_unit.sv @@
// Top level of the geometry string parser with its stream ports and result buffer.
//
// Parses WxH+X+Y strings that arrive one byte per word and returns one result word per
// string, on its last byte or its first zero byte. A byte is taken in every cycle while
// s_tready is high; the only work per byte is one multiply-by-ten and add on the current
// field, done between the parser state register and the result register. The result word
// is registered there, or in the skid entry while the result register is stalled. The
// result side has two entries, so s_tready drops only when two results wait to be taken.
`timescale 1ns / 1ps
`default_nettype none
module rect_geometry_text_parser_unit #(
	parameter int unsigned FIELD_CHARS = rgtp_pkg::FIELD_CHARS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_tvalid,
	output logic                       s_tready,
	input  logic [7:0]                 s_tdata,  // [7:0] text_byte
	input  logic                       s_tlast,  // string_end
	output logic                       m_tvalid,
	input  logic                       m_tready,
	// [17:0] rect_width, [35:18] rect_height, [53:36] offset_x, [71:54] offset_y,
	// [74:72] fields_found, rest zero
	output logic [rgtp_pkg::OUT_W-1:0] m_tdata
);
	import rgtp_pkg::*;

	parse_state_t     state_q;
	logic             finished_q;
	parse_state_t     after_char;
	parse_state_t     after_sel;
	parse_state_t     after_end;
	logic             accept;
	logic             str_ends;
	logic             res_valid;
	logic [OUT_W-1:0] res_data;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	logic             skid_valid_q;
	logic [OUT_W-1:0] skid_data_q;
	logic             drain;

	rgtp_feed #(.FIELD_CHARS(FIELD_CHARS)) u_feed_char (
		.cur      (state_q),
		.ch       (s_tdata),
		.end_mark (1'b0),
		.nxt      (after_char)
	);

	// a zero byte is not parsed, it only ends the string
	assign after_sel = (s_tdata == 8'h00) ? state_q : after_char;

	rgtp_feed #(.FIELD_CHARS(FIELD_CHARS)) u_feed_end (
		.cur      (after_sel),
		.ch       (s_tdata),
		.end_mark (1'b1),
		.nxt      (after_end)
	);

	assign s_tready  = !skid_valid_q;
	assign accept    = s_tvalid && s_tready;
	assign str_ends  = (s_tdata == 8'h00) || s_tlast;
	assign res_valid = accept && !finished_q && str_ends;
	assign res_data  = {{(OUT_W - RES_BITS){1'b0}}, after_end.count,
		after_end.vals[3], after_end.vals[2], after_end.vals[1], after_end.vals[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= PARSE_RESET;
			finished_q <= 1'b0;
		end else if (accept) begin
			if (finished_q) begin
				// drop bytes up to the string's last one
				if (s_tlast) begin
					state_q    <= PARSE_RESET;
					finished_q <= 1'b0;
				end
			end else if (str_ends) begin
				state_q    <= PARSE_RESET;
				finished_q <= !s_tlast;
			end else begin
				state_q <= after_sel;
			end
		end
	end

	assign drain = out_valid_q && m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (drain) begin
				skid_valid_q <= 1'b0;
			end
		end else if (res_valid) begin
			if (out_valid_q && !m_tready) begin
				skid_valid_q <= 1'b1;
			end else begin
				out_valid_q <= 1'b1;
			end
		end else if (drain) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (drain) begin
				out_data_q <= skid_data_q;
			end
		end else if (res_valid) begin
			if (out_valid_q && !m_tready) begin
				skid_data_q <= res_data;
			end else begin
				out_data_q <= res_data;
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
`default_nettype wire

@@ src/rgtp_feed.sv @@
// Next-state logic of the parser for one character or for the end of the string.
`timescale 1ns / 1ps
`default_nettype none
module rgtp_feed #(
	parameter int unsigned FIELD_CHARS = rgtp_pkg::FIELD_CHARS_DEF
) (
	input  rgtp_pkg::parse_state_t cur,
	input  logic [7:0]             ch,
	input  logic                   end_mark,
	output rgtp_pkg::parse_state_t nxt
);
	import rgtp_pkg::*;

	localparam logic [CHARS_W-1:0] CHARS_LIM = CHARS_W'(FIELD_CHARS);

	logic               is_digit;
	logic               is_plus;
	logic               is_minus;
	logic               is_x;
	logic [ACC_W+3:0]   acc_ext;
	logic [ACC_W+3:0]   acc_next;
	logic [ACC_W-1:0]   acc_sat;
	logic [VAL_W-1:0]   field_val;
	logic [1:0]         slot;
	logic               field_fail;
	stage_t             stage_after;
	logic               done;

	assign is_digit = !end_mark && (ch >= CH_ZERO) && (ch <= CH_NINE);
	assign is_plus  = !end_mark && (ch == CH_PLUS);
	assign is_minus = !end_mark && (ch == CH_MINUS);
	assign is_x     = !end_mark && (ch == CH_X);

	// acc * 10 + digit, then clamp
	assign acc_ext  = {4'b0000, cur.acc};
	assign acc_next = (acc_ext << 3) + (acc_ext << 1) + {{ACC_W{1'b0}}, ch[3:0]};
	assign acc_sat  = (acc_next > {4'b0000, ACC_MAX}) ? ACC_MAX : acc_next[ACC_W-1:0];

	assign field_val  = cur.neg ? (-{1'b0, cur.acc}) : {1'b0, cur.acc};
	assign field_fail = cur.neg ? (cur.chars == CHARS_W'(1)) : (cur.chars == '0);

	always_comb begin
		case (cur.stage)
			ST_WIDTH:  slot = 2'd0;
			ST_HEIGHT: slot = 2'd1;
			ST_XOFF:   slot = 2'd2;
			ST_YOFF:   slot = 2'd3;
			default:   slot = 2'd0;
		endcase
	end

	always_comb begin
		case (cur.stage)
			ST_WIDTH:  stage_after = ST_SEP;
			ST_HEIGHT: stage_after = ST_XOFF;
			ST_XOFF:   stage_after = ST_YOFF;
			default:   stage_after = ST_DONE;
		endcase
	end

	always_comb begin
		nxt  = cur;
		done = 1'b0;
		if (cur.stage != ST_DONE) begin
			// separator after width: 'x' opens height, anything else goes to x offset
			if (nxt.stage == ST_SEP) begin
				nxt.phase = 1'b0;
				nxt.neg   = 1'b0;
				nxt.chars = '0;
				nxt.acc   = '0;
				if (is_x) begin
					nxt.stage = ST_HEIGHT;
					done      = 1'b1;
				end else begin
					nxt.stage = ST_XOFF;
				end
			end
			if (!done && !nxt.phase) begin
				if ((nxt.stage == ST_XOFF || nxt.stage == ST_YOFF) && !is_plus && !is_minus) begin
					nxt.stage = ST_DONE;
					done      = 1'b1;
				end else begin
					nxt.phase = 1'b1;
					if (is_minus || is_plus) begin
						nxt.neg   = is_minus;
						nxt.chars = CHARS_W'(1);
						done      = 1'b1;
					end
				end
			end
			if (!done) begin
				if ((nxt.chars < CHARS_LIM) && is_digit) begin
					nxt.acc   = acc_sat;
					nxt.chars = nxt.chars + CHARS_W'(1);
				end else if (field_fail) begin
					nxt.stage = ST_DONE;
				end else begin
					// close the field, then let the character open the next one
					nxt.vals[slot] = field_val;
					nxt.count      = nxt.count + CNT_W'(1);
					nxt.phase      = 1'b0;
					nxt.neg        = 1'b0;
					nxt.chars      = '0;
					nxt.acc        = '0;
					nxt.stage      = stage_after;
					if (stage_after == ST_SEP) begin
						nxt.stage = is_x ? ST_HEIGHT : ST_XOFF;
					end
					if (nxt.stage == ST_XOFF || nxt.stage == ST_YOFF) begin
						if (is_plus || is_minus) begin
							nxt.phase = 1'b1;
							nxt.neg   = is_minus;
							nxt.chars = CHARS_W'(1);
						end else begin
							nxt.stage = ST_DONE;
						end
					end
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ src/rgtp_checker.sv @@
// Port-level assertions for the geometry string parser and their bind.
`timescale 1ns / 1ps
`default_nettype none
module rgtp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [79:0] m_tdata
);

	// a stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result word changed while stalled");

	// input backs up only behind a full result side
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid)
		else $error("input stalled with no result pending");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[79:75] == 5'd0) && (m_tdata[74:72] <= 3'd4))
		else $error("bad field count or padding");

	// fields fail in order, so unparsed fields read zero
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[74:72] == 3'd0) |-> (m_tdata[71:0] == 72'd0))
		else $error("values present with no field parsed");

	a_height_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[74:72] == 3'd1) |-> (m_tdata[71:18] == 54'd0))
		else $error("later fields present after one field");

endmodule

bind rect_geometry_text_parser_unit rgtp_checker u_rgtp_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
`default_nettype wire
